>>> design/radial_vignetting_gain_top_assert.svh
// Assertion macros used by the top-level design file.
`ifndef RADIAL_VIGNETTING_GAIN_TOP_ASSERT_SVH
`define RADIAL_VIGNETTING_GAIN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RVG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvg assertion failed");
`define RVG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvg assertion failed");
`else
`define RVG_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define RVG_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> design/rvg_pkg.sv
package rvg_pkg;

  localparam int POS_W     = 12;
  localparam int SAMPLE_W  = 16;
  localparam int CTR_W     = 14;
  localparam int INDEX_W   = 12;
  localparam int EGAIN_W   = 24;
  localparam int ABS_W     = 14;
  localparam int SQ_W      = 2 * ABS_W + 2;
  localparam int ROOT_W    = ABS_W + 1;
  localparam int SCALED_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE     = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic [SAMPLE_W-1:0] LIM_NARROW = 16'd255;
  localparam logic [SAMPLE_W-1:0] LIM_WIDE   = 16'd65535;

  typedef struct packed {
    logic                action;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
    logic [SAMPLE_W-1:0] alpha_in;
    logic [INDEX_W-1:0]  entry_index;
    logic [EGAIN_W-1:0]  entry_gain;
  } in_pay_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;
    logic [SAMPLE_W-1:0] alpha_out;
  } out_pay_t;

  typedef struct packed {
    logic                is_pix;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] alpha;
    logic [INDEX_W-1:0]  entry_index;
    logic [EGAIN_W-1:0]  entry_gain;
  } side_t;

endpackage

>>> design/rvg_stream_if.sv
interface rvg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/rvg_radius.sv
module rvg_radius #(
  parameter int COORD_BITS   = 12,
  parameter int GAIN_ENTRIES = 4096,
  localparam int IDX_W = $clog2(GAIN_ENTRIES)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               vld_in,
  input  logic [rvg_pkg::POS_W-1:0]          pos_x,
  input  logic [rvg_pkg::POS_W-1:0]          pos_y,
  input  logic signed [rvg_pkg::CTR_W-1:0]   center_x,
  input  logic signed [rvg_pkg::CTR_W-1:0]   center_y,
  input  rvg_pkg::side_t                     side_in,
  output logic                               vld_out,
  output logic [IDX_W-1:0]                   idx_out,
  output rvg_pkg::side_t                     side_out
);

  localparam int PW = rvg_pkg::POS_W;
  localparam int DW = rvg_pkg::CTR_W + 1;
  localparam int AW = rvg_pkg::ABS_W;
  localparam int SW = rvg_pkg::SQ_W;
  localparam int N  = rvg_pkg::ROOT_W;
  localparam int TW = SW + 2;
  localparam int unsigned CMASK = (1 << COORD_BITS) - 1;

  logic [PW-1:0]        px, py;
  logic signed [DW-1:0] dx, dy;
  logic [AW-1:0]        ax, ay;

  logic                 s1_vld_r, s2_vld_r;
  logic [AW-1:0]        ax_r, ay_r;
  rvg_pkg::side_t       s1_side_r, s2_side_r;
  logic [2*AW-1:0]      sqx_r, sqy_r;

  logic [N:0]           vld_r;
  logic [SW-1:0]        rem_r    [N+1];
  logic [N-1:0]         root_r   [N+1];
  rvg_pkg::side_t       side_r   [N+1];
  logic [SW-1:0]        rem_nxt  [N];
  logic [N-1:0]         root_nxt [N];

  logic                 up;
  logic [N:0]           rnd_dist;
  logic [IDX_W-1:0]     idx_nxt;
  logic                 fin_vld_r;
  logic [IDX_W-1:0]     idx_r;
  rvg_pkg::side_t       fin_side_r;

  assign px = pos_x & PW'(CMASK);
  assign py = pos_y & PW'(CMASK);
  assign dx = $signed(DW'(px)) - DW'(center_x);
  assign dy = $signed(DW'(py)) - DW'(center_y);
  assign ax = AW'(dx[DW-1] ? -dx : dx);
  assign ay = AW'(dy[DW-1] ? -dy : dy);

  for (genvar j = 0; j < N; j++) begin : g_sqrt
    localparam int B = N - 1 - j;
    logic [TW-1:0] trial;
    assign trial = (TW'(root_r[j]) << (B + 1)) | (TW'(1) << (2 * B));
    always_comb begin
      if (TW'(rem_r[j]) >= trial) begin
        rem_nxt[j]  = SW'(TW'(rem_r[j]) - trial);
        root_nxt[j] = root_r[j] | (N'(1) << B);
      end else begin
        rem_nxt[j]  = rem_r[j];
        root_nxt[j] = root_r[j];
      end
    end
  end

  assign up       = rem_r[N] > SW'(root_r[N]);
  assign rnd_dist = (N+1)'(root_r[N]) + (N+1)'(up);
  assign idx_nxt  = (32'(rnd_dist) >= GAIN_ENTRIES) ? IDX_W'(GAIN_ENTRIES - 1)
                                                    : IDX_W'(rnd_dist);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      vld_r     <= '0;
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= vld_in;
      s2_vld_r  <= s1_vld_r;
      vld_r     <= {vld_r[N-1:0], s2_vld_r};
      fin_vld_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r      <= ax;
      ay_r      <= ay;
      s1_side_r <= side_in;
      sqx_r     <= ax_r * ax_r;
      sqy_r     <= ay_r * ay_r;
      s2_side_r <= s1_side_r;
      rem_r[0]  <= SW'(sqx_r) + SW'(sqy_r);
      root_r[0] <= '0;
      side_r[0] <= s2_side_r;
      for (int j = 0; j < N; j++) begin
        rem_r[j+1]  <= rem_nxt[j];
        root_r[j+1] <= root_nxt[j];
        side_r[j+1] <= side_r[j];
      end
      idx_r      <= idx_nxt;
      fin_side_r <= side_r[N];
    end
  end

  assign vld_out  = fin_vld_r;
  assign idx_out  = idx_r;
  assign side_out = fin_side_r;

endmodule

>>> design/rvg_lane.sv
module rvg_lane #(
  parameter int GAIN_FRAC_BITS = 16,
  localparam int GW = 8 + GAIN_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [rvg_pkg::SAMPLE_W-1:0]     sample,
  input  logic [GW-1:0]                    gain,
  output logic [rvg_pkg::SCALED_W-1:0]     scaled
);

  localparam int PW = rvg_pkg::SAMPLE_W + GW;

  logic [PW-1:0]                   product;
  logic [rvg_pkg::SCALED_W-1:0]    scaled_r;

  assign product = PW'(sample) * PW'(gain);

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_r <= product[PW-1:GAIN_FRAC_BITS];
    end
  end

  assign scaled = scaled_r;

endmodule

>>> design/rvg_merge.sv
module rvg_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             vld_in,
  input  logic [rvg_pkg::SCALED_W-1:0]     red,
  input  logic [rvg_pkg::SCALED_W-1:0]     green,
  input  logic [rvg_pkg::SCALED_W-1:0]     blue,
  input  logic [rvg_pkg::SAMPLE_W-1:0]     alpha,
  input  logic                             wide,
  output logic                             vld_out,
  output rvg_pkg::out_pay_t                pay_out
);

  localparam int XW = rvg_pkg::SCALED_W;
  localparam int OW = rvg_pkg::SAMPLE_W;

  function automatic logic [OW-1:0] clamp(input logic [XW-1:0] v, input logic w);
    logic [OW-1:0] lim;
    lim = w ? rvg_pkg::LIM_WIDE : rvg_pkg::LIM_NARROW;
    return (v > XW'(lim)) ? lim : v[OW-1:0];
  endfunction

  logic              vld_r;
  rvg_pkg::out_pay_t pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_r.red_out   <= clamp(red, wide);
      pay_r.green_out <= clamp(green, wide);
      pay_r.blue_out  <= clamp(blue, wide);
      pay_r.alpha_out <= alpha;
    end
  end

  assign vld_out = vld_r;
  assign pay_out = pay_r;

endmodule

>>> design/radial_vignetting_gain_top.sv
// Radial gain correction, one beat per clock while the output is not stalled. Each input
// beat either writes one gain table entry (no result) or carries an RGBA pixel, which
// yields one result beat after the square root of the squared distance, solved one root
// bit per pipeline stage, the table read, the R, G, B multiply lanes and the clamping
// output register. The pipeline advances whenever the output register is empty or taken,
// so a stalled output holds everything behind it. Load the table and the centre and width
// registers before streaming pixels, and write registers only while no beat is in flight.
`include "radial_vignetting_gain_top_assert.svh"

module radial_vignetting_gain_top #(
  parameter int COORD_BITS     = 12,
  parameter int GAIN_ENTRIES   = 4096,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rvg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rvg_pkg::CTR_W-1:0]         cfg_wdata,
  rvg_stream_if.sink                        in_bus,
  rvg_stream_if.source                      out_bus
);

  localparam int IDX_W = $clog2(GAIN_ENTRIES);
  localparam int GW    = 8 + GAIN_FRAC_BITS;

  logic signed [rvg_pkg::CTR_W-1:0] cx_r, cy_r;
  logic                             wide_r;

  logic                             adv;
  rvg_pkg::in_pay_t                 ip;
  rvg_pkg::side_t                   side_in;

  logic                             rad_vld;
  logic [IDX_W-1:0]                 rad_idx;
  rvg_pkg::side_t                   rad_side;
  logic                             wr_ok;
  logic [IDX_W-1:0]                 waddr;

  logic [GW-1:0]                    mem [GAIN_ENTRIES];
  logic [GW-1:0]                    gain_rd_r;
  logic                             mem_vld_r;
  rvg_pkg::side_t                   mem_side_r;

  logic                             lane_vld_r;
  logic [rvg_pkg::SAMPLE_W-1:0]     lane_alpha_r;
  logic [rvg_pkg::SCALED_W-1:0]     sc_red, sc_green, sc_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      wide_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rvg_pkg::CFG_CENTER_X: cx_r   <= cfg_wdata;
        rvg_pkg::CFG_CENTER_Y: cy_r   <= cfg_wdata;
        rvg_pkg::CFG_WIDE:     wide_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign adv          = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = adv;
  assign ip           = in_bus.payload;

  always_comb begin
    side_in.is_pix      = (ip.action == rvg_pkg::ACT_PIXEL);
    side_in.red         = ip.red_in;
    side_in.green       = ip.green_in;
    side_in.blue        = ip.blue_in;
    side_in.alpha       = ip.alpha_in;
    side_in.entry_index = ip.entry_index;
    side_in.entry_gain  = ip.entry_gain;
  end

  rvg_radius #(
    .COORD_BITS   (COORD_BITS),
    .GAIN_ENTRIES (GAIN_ENTRIES)
  ) u_radius (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .vld_in   (in_bus.valid),
    .pos_x    (ip.pos_x),
    .pos_y    (ip.pos_y),
    .center_x (cx_r),
    .center_y (cy_r),
    .side_in  (side_in),
    .vld_out  (rad_vld),
    .idx_out  (rad_idx),
    .side_out (rad_side)
  );

  assign wr_ok = 32'(rad_side.entry_index) < GAIN_ENTRIES;
  assign waddr = IDX_W'(32'(rad_side.entry_index));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (rad_vld && !rad_side.is_pix && wr_ok) begin
        mem[waddr] <= GW'(rad_side.entry_gain);
      end
      gain_rd_r  <= mem[rad_idx];
      mem_side_r <= rad_side;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r  <= 1'b0;
      lane_vld_r <= 1'b0;
    end else if (adv) begin
      mem_vld_r  <= rad_vld && rad_side.is_pix;
      lane_vld_r <= mem_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_alpha_r <= mem_side_r.alpha;
    end
  end

  rvg_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_red (
    .clk    (clk),
    .adv    (adv),
    .sample (mem_side_r.red),
    .gain   (gain_rd_r),
    .scaled (sc_red)
  );

  rvg_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_green (
    .clk    (clk),
    .adv    (adv),
    .sample (mem_side_r.green),
    .gain   (gain_rd_r),
    .scaled (sc_green)
  );

  rvg_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_blue (
    .clk    (clk),
    .adv    (adv),
    .sample (mem_side_r.blue),
    .gain   (gain_rd_r),
    .scaled (sc_blue)
  );

  rvg_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_in  (lane_vld_r),
    .red     (sc_red),
    .green   (sc_green),
    .blue    (sc_blue),
    .alpha   (lane_alpha_r),
    .wide    (wide_r),
    .vld_out (out_bus.valid),
    .pay_out (out_bus.payload)
  );

  `RVG_ASSERT_NXT(a_write_no_result, clk, rst_n, adv && rad_vld && !rad_side.is_pix, !mem_vld_r)
  `RVG_ASSERT_NXT(a_lane_to_out, clk, rst_n, adv && lane_vld_r, out_bus.valid)
  `RVG_ASSERT_NXT(a_stall_holds_lane, clk, rst_n, !adv && lane_vld_r, lane_vld_r)
  `RVG_ASSERT_IMP(a_mem_stage_pixel, clk, rst_n, mem_vld_r, mem_side_r.is_pix)

endmodule
